@@ hw/rtl/smmc_pkg.sv @@
// Shared types and constants for the subset mask match counter.
package smmc_pkg;

   // Width of one input item's bit position field.
   localparam int BIT_INDEX_W = 6;

   // Mask bits held by one compare cell.
   localparam int CELL_BITS   = 8;
   localparam int CELL_OFS_W  = $clog2(CELL_BITS);
   localparam int CELL_SEL_W  = BIT_INDEX_W - CELL_OFS_W;

   // Result count width and its saturation value.
   localparam int COUNT_W               = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Stream data widths, whole bytes.
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   // Operation codes carried in the low bits of req_tdata.
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Mask update control broadcast to every cell.
   typedef struct packed {
      logic                   set;
      logic                   clr;
      logic [BIT_INDEX_W-1:0] bit_index;
   } cell_ctrl_type;

   // Per-entry status that travels down the cell chain beside the entry.
   typedef struct packed {
      logic vld;
      logic tail;
      logic match;
   } scan_flow_type;

endpackage

@@ hw/rtl/subset_mask_match_counter_unit.sv @@
// Top level of the subset mask match counter: entry table, cell chain and query sequencer.
//
// The block keeps a table of up to MAX_ENTRIES set masks, each MASK_BITS wide. Load and
// query transactions each add up to one bit position to a shared building mask; the transaction
// with tlast high ends the mask. A load stores it as the next table entry (loads beyond
// capacity are dropped), a query counts the stored entries that are subsets of it and
// returns that count, saturated at 2047, as one result transaction. A clear transaction
// empties the table. During a final query the table memory has one read port and delivers one
// entry per cycle, and every entry then walks through the chain of NCELLS compare cells (one
// per 8 mask bits) before it is counted. An empty table answers without a scan. The input
// side is not ready while a query runs; a finished count sits in an output register, so the
// next transactions are taken while it waits to be read.
module subset_mask_match_counter_unit #(
   parameter int MAX_ENTRIES = 1024,
   parameter int MASK_BITS   = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata fields from bit 0: op [1:0], bit_index [7:2], bit_valid [8], zero fill.
   input  logic [smmc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,
   // Response stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata fields from bit 0: match_count [10:0], zero fill.
   output logic [smmc_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   // The mask is split into cells of CELL_BITS bits; the last cell may carry unused padding.
   localparam int NCELLS = (MASK_BITS + smmc_pkg::CELL_BITS - 1) / smmc_pkg::CELL_BITS;
   localparam int PAD_W  = NCELLS * smmc_pkg::CELL_BITS;
   localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

   // Request fields.
   logic [1:0]                         req_op;
   logic [smmc_pkg::BIT_INDEX_W-1:0]   req_bit_index;
   logic                               req_bit_valid;
   logic                               req_accept;
   logic                               bit_ok;

   assign req_op        = req_tdata[1:0];
   assign req_bit_index = req_tdata[7:2];
   assign req_bit_valid = req_tdata[8];
   assign req_accept    = req_tvalid && req_tready;

   // Positions at or above MASK_BITS are ignored.
   assign bit_ok = req_bit_valid && (int'(req_bit_index) < MASK_BITS);

   // Control state.
   smmc_pkg::state_type                state_ff;
   smmc_pkg::state_type                state_in;
   logic [CNT_W-1:0]                   entry_count_ff;
   logic [CNT_W-1:0]                   entry_count_in;
   logic [AW-1:0]                      rd_ptr_ff;
   logic [AW-1:0]                      rd_ptr_in;
   logic [smmc_pkg::COUNT_W-1:0]       acc_ff;
   logic [smmc_pkg::COUNT_W-1:0]       acc_in;
   smmc_pkg::scan_flow_type            issue_flow_ff;
   smmc_pkg::scan_flow_type            issue_flow_in;
   logic                               rsp_vld_ff;
   logic                               rsp_vld_in;
   logic [smmc_pkg::COUNT_W-1:0]       rsp_data_ff;

   // Decoded events.
   logic                               do_clear;
   logic                               do_load_end;
   logic                               do_query_end;
   logic                               table_empty;
   logic                               table_full;
   logic                               issue_tail;
   logic                               chain_tail;

   // Sequencer outputs.
   logic                               seq_ready;
   logic                               seq_issue;
   logic                               seq_out_load;

   // Mask and chain signals.
   smmc_pkg::cell_ctrl_type            cell_ctrl;
   smmc_pkg::scan_flow_type            flow   [NCELLS+1];
   logic [PAD_W-1:0]                   entry  [NCELLS+1];
   logic [PAD_W-1:0]                   mask_q;
   logic [PAD_W-1:0]                   bit_onehot;
   logic [PAD_W-1:0]                   mask_wr;
   logic [MASK_BITS-1:0]               rd_data;

   assign do_clear     = req_accept && (req_op == smmc_pkg::OP_CLEAR);
   assign do_load_end  = req_accept && (req_op == smmc_pkg::OP_LOAD) && req_tlast;
   assign do_query_end = req_accept && (req_op == smmc_pkg::OP_QUERY) && req_tlast;
   assign table_empty  = (entry_count_ff == '0);
   assign table_full   = (entry_count_ff == CNT_W'(MAX_ENTRIES));
   assign issue_tail   = ((CNT_W+1)'(rd_ptr_ff) + (CNT_W+1)'(1)) == (CNT_W+1)'(entry_count_ff);
   assign chain_tail   = flow[NCELLS].vld && flow[NCELLS].tail;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smmc_pkg::ST_IDLE: begin
            if (do_query_end) begin
               state_in = table_empty ? smmc_pkg::ST_DONE : smmc_pkg::ST_SCAN;
            end
         end
         smmc_pkg::ST_SCAN: begin
            if (issue_tail) begin
               state_in = smmc_pkg::ST_DRAIN;
            end
         end
         smmc_pkg::ST_DRAIN: begin
            if (chain_tail) begin
               state_in = smmc_pkg::ST_DONE;
            end
         end
         smmc_pkg::ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               state_in = smmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smmc_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      seq_ready    = 1'b0;
      seq_issue    = 1'b0;
      seq_out_load = 1'b0;
      unique case (state_ff)
         smmc_pkg::ST_IDLE: begin
            seq_ready = 1'b1;
         end
         smmc_pkg::ST_SCAN: begin
            seq_issue = 1'b1;
         end
         smmc_pkg::ST_DRAIN: begin
            seq_issue = 1'b0;
         end
         smmc_pkg::ST_DONE: begin
            seq_out_load = !rsp_vld_ff || rsp_tready;
         end
         default: begin
            seq_ready = 1'b0;
         end
      endcase
   end

   assign req_tready = seq_ready;

   // The building mask is cleared when a load ends, on a clear, and once a query is counted.
   always_comb begin
      cell_ctrl.bit_index = req_bit_index;
      cell_ctrl.set = req_accept && bit_ok &&
                      ((req_op == smmc_pkg::OP_LOAD) || (req_op == smmc_pkg::OP_QUERY));
      cell_ctrl.clr = do_clear || do_load_end || (do_query_end && table_empty) ||
                      ((state_ff == smmc_pkg::ST_DRAIN) && chain_tail);
   end

   // Table fill count.
   always_comb begin
      entry_count_in = entry_count_ff;
      if (do_clear) begin
         entry_count_in = '0;
      end else if (do_load_end && !table_full) begin
         entry_count_in = entry_count_ff + CNT_W'(1);
      end
   end

   // Read pointer walks the stored entries during a scan.
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (do_query_end) begin
         rd_ptr_in = '0;
      end else if (seq_issue) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
      end
   end

   // Status that travels with each read, aligned to the registered read data.
   always_comb begin
      issue_flow_in.vld   = seq_issue;
      issue_flow_in.tail  = issue_tail;
      issue_flow_in.match = 1'b1;
   end

   // Saturating count of entries that leave the chain still matching.
   always_comb begin
      acc_in = acc_ff;
      if (do_query_end) begin
         acc_in = '0;
      end else if (flow[NCELLS].vld && flow[NCELLS].match && (acc_ff != smmc_pkg::COUNT_MAX)) begin
         acc_in = acc_ff + smmc_pkg::COUNT_W'(1);
      end
   end

   // Output register.
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (seq_out_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= smmc_pkg::ST_IDLE;
         entry_count_ff <= '0;
         rd_ptr_ff      <= '0;
         acc_ff         <= '0;
         issue_flow_ff  <= '0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         rd_ptr_ff      <= rd_ptr_in;
         acc_ff         <= acc_in;
         issue_flow_ff  <= issue_flow_in;
         rsp_vld_ff     <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_out_load) begin
         rsp_data_ff <= acc_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = smmc_pkg::RSP_TDATA_W'(rsp_data_ff);

   // The entry written on a load includes the bit carried by the final transaction.
   assign bit_onehot = bit_ok ? (PAD_W'(1) << req_bit_index) : '0;
   assign mask_wr    = mask_q | bit_onehot;

   smmc_table #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW),
      .WIDTH (MASK_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (do_load_end && !table_full),
      .wr_addr (entry_count_ff[AW-1:0]),
      .wr_data (mask_wr[MASK_BITS-1:0]),
      .rd_en   (seq_issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign flow[0]  = issue_flow_ff;
   assign entry[0] = PAD_W'(rd_data);

   // Each cell owns one slice of the building mask and passes the entry on every cycle.
   for (genvar gi = 0; gi < NCELLS; gi++) begin : g_cell
      smmc_cell #(
         .CELL_IDX (gi),
         .PAD_W    (PAD_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .flow_in    (flow[gi]),
         .entry_in   (entry[gi]),
         .flow_out   (flow[gi+1]),
         .entry_out  (entry[gi+1]),
         .mask_slice (mask_q[gi*smmc_pkg::CELL_BITS +: smmc_pkg::CELL_BITS])
      );
   end

endmodule

@@ hw/rtl/smmc_cell.sv @@
// One compare cell: holds a slice of the building mask and checks that slice of a passing entry.
module smmc_cell #(
   parameter int CELL_IDX = 0,
   parameter int PAD_W    = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  smmc_pkg::cell_ctrl_type               ctrl,
   input  smmc_pkg::scan_flow_type               flow_in,
   input  logic [PAD_W-1:0]                      entry_in,
   output smmc_pkg::scan_flow_type               flow_out,
   output logic [PAD_W-1:0]                      entry_out,
   output logic [smmc_pkg::CELL_BITS-1:0]        mask_slice
);

   logic [smmc_pkg::CELL_BITS-1:0] mask_ff;
   logic [smmc_pkg::CELL_BITS-1:0] mask_in;
   logic [smmc_pkg::CELL_BITS-1:0] bit_onehot;
   smmc_pkg::scan_flow_type        flow_ff;
   smmc_pkg::scan_flow_type        flow_in_next;
   logic [PAD_W-1:0]               entry_ff;
   logic                           hit;
   logic                           slice_ok;

   // The upper bits of the position pick the cell, the lower bits the bit in its slice.
   assign hit = ctrl.set &&
      (ctrl.bit_index[smmc_pkg::BIT_INDEX_W-1 -: smmc_pkg::CELL_SEL_W] ==
       smmc_pkg::CELL_SEL_W'(CELL_IDX));
   assign bit_onehot = smmc_pkg::CELL_BITS'(1) << ctrl.bit_index[smmc_pkg::CELL_OFS_W-1:0];

   always_comb begin
      if (ctrl.clr) begin
         mask_in = '0;
      end else if (hit) begin
         mask_in = mask_ff | bit_onehot;
      end else begin
         mask_in = mask_ff;
      end
   end

   // An entry stays a subset only if none of its bits in this slice lie outside the mask.
   assign slice_ok = ((entry_in[CELL_IDX*smmc_pkg::CELL_BITS +: smmc_pkg::CELL_BITS] &
                       ~mask_ff) == '0);

   always_comb begin
      flow_in_next       = flow_in;
      flow_in_next.match = flow_in.match & slice_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         flow_ff <= '0;
      end else begin
         mask_ff <= mask_in;
         flow_ff <= flow_in_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign flow_out   = flow_ff;
   assign entry_out  = entry_ff;
   assign mask_slice = mask_ff;

endmodule

@@ hw/rtl/smmc_table.sv @@
// Entry table memory: one write port and one registered read port.
module smmc_table #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
